### hdl/assert_macros.svh
// Assertion macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

### hdl/bbcc_pkg.sv
// Package: types, constants and command codes of the buffer cache controller
`timescale 1ns / 1ps
package bbcc_pkg;
	localparam int ENTRIES_DEF = 32;
	localparam int COUNT_BITS_DEF = 8;
	localparam int FLUSH_MAX = 32;

	typedef enum logic [2:0] {
		CMD_GET = 3'd0,
		CMD_NEW = 3'd1,
		CMD_RELEASE = 3'd2,
		CMD_MARK = 3'd3,
		CMD_FLUSH = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_HIT = 3'd0,
		ST_ALLOC = 3'd1,
		ST_RANGE = 3'd2,
		ST_NOFREE = 3'd3,
		ST_DONE = 3'd4,
		ST_UNDER = 3'd5,
		ST_FLUSH = 3'd6
	} status_t;

	typedef struct packed {
		logic [2:0] command;
		logic [31:0] block_number;
		logic [4:0] slot;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] result_slot;
		logic read_request;
		logic clear_request;
		logic writeback_request;
		logic [31:0] writeback_block;
		logic last;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request
		logic scan_step; // advance scan pointer
		logic commit;    // apply lookup result
		logic rel;       // apply release
		logic mark;      // apply mark
		logic flush_hit; // clear dirty at scan pointer and emit
		logic emit_res;  // emit a single result
		logic emit_none; // flush with no dirty entry
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_lookup;
		logic is_rel_mark;
		logic is_flush;
		logic scan_done;
		logic hit_found;
		logic dirty_here;
		logic any_flushed;
		logic flush_full;
	} sts_t;
endpackage

### hdl/block_buffer_cache_control_core.sv
// Top level of the disk-block buffer cache controller
`timescale 1ns / 1ps
// An item is taken when start is high and busy low. Get and new keep busy
// high through one tag/victim scan step per entry (no scan when the block
// is out of range); release and mark skip the scan, flush all scans too.
// The next item can be taken as soon as busy is low. Results appear for
// one cycle each on rsp with done high while busy; the receiver cannot
// stall, the last result has last set. block_limit is to be written
// through cfg_we/cfg_wdata only while idle; the block does not enforce it.
module block_buffer_cache_control_core #(
	parameter int ENTRIES = bbcc_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = bbcc_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bbcc_pkg::req_t req,
	output logic done,
	output bbcc_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [31:0] cfg_wdata
);
	import bbcc_pkg::*;

	ctl_t ctl;
	sts_t sts;

	bbcc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .ctl(ctl), .busy(busy)
	);

	bbcc_dp #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .ctl(ctl), .sts(sts), .rsp(rsp), .rsp_valid(done)
	);
endmodule

### hdl/bbcc_ctrl.sv
// Controller state machine of the buffer cache controller
`timescale 1ns / 1ps
module bbcc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input bbcc_pkg::sts_t sts,
	output bbcc_pkg::ctl_t ctl,
	output logic busy
);
	import bbcc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEC = 5'b00010,
		S_SCAN = 5'b00100,
		S_FLUSH = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		ctl = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_lookup) begin
					state_d = S_SCAN;
				end else if (sts.is_rel_mark) begin
					ctl.rel = 1'b1;
					ctl.mark = 1'b1;
					ctl.emit_res = 1'b1;
					state_d = S_DONE;
				end else if (sts.is_flush) begin
					state_d = S_FLUSH;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					ctl.commit = 1'b1;
					ctl.emit_res = 1'b1;
					state_d = S_DONE;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			S_FLUSH: begin
				if (sts.scan_done || sts.flush_full) begin
					if (!sts.any_flushed) ctl.emit_none = 1'b1;
					state_d = S_DONE;
				end else begin
					ctl.flush_hit = sts.dirty_here;
					ctl.scan_step = 1'b1;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
endmodule

### hdl/bbcc_dp.sv
// Datapath of the buffer cache controller: entry table, scan and result
`timescale 1ns / 1ps
module bbcc_dp #(
	parameter int ENTRIES = bbcc_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = bbcc_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input bbcc_pkg::req_t req,
	input bbcc_pkg::ctl_t ctl,
	output bbcc_pkg::sts_t sts,
	output bbcc_pkg::rsp_t rsp,
	output logic rsp_valid
);
	import bbcc_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = IW + 1;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;
	localparam logic [CW-1:0] NENT = CW'(ENTRIES);

	logic [31:0] limit_q;
	logic valid_q [ENTRIES];
	logic dirty_q [ENTRIES];
	logic [31:0] tag_q [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_q [ENTRIES];
	logic [IW-1:0] last_q;

	req_t r_q;
	logic [CW-1:0] scan_q;      // steps taken
	logic [IW-1:0] vic_q;       // victim scan pointer
	logic hit_q, free_q;
	logic [IW-1:0] hslot_q, fslot_q;
	logic [5:0] nflush_q;
	logic [IW-1:0] sp;
	logic [IW-1:0] vp;
	logic [IW-1:0] sl_idx;
	logic slot_ok;
	logic lookup_cmd, range_ok;

	assign sp = scan_q[IW-1:0];
	assign vp = (vic_q == IW'(ENTRIES - 1)) ? '0 : vic_q + 1'b1;
	assign sl_idx = IW'(r_q.slot);
	assign slot_ok = (int'(r_q.slot) < ENTRIES);
	assign lookup_cmd = (r_q.command == CMD_GET) || (r_q.command == CMD_NEW);
	assign range_ok = (r_q.block_number < limit_q);

	assign sts.is_lookup = lookup_cmd;
	assign sts.is_rel_mark = (r_q.command == CMD_RELEASE) || (r_q.command == CMD_MARK);
	assign sts.is_flush = (r_q.command == CMD_FLUSH);
	assign sts.scan_done = (scan_q == NENT) || (lookup_cmd && !range_ok);
	assign sts.hit_found = hit_q;
	assign sts.dirty_here = (scan_q != NENT) && dirty_q[sp];
	assign sts.any_flushed = (nflush_q != 6'd0);
	assign sts.flush_full = (nflush_q == 6'(FLUSH_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= '0;
		else if (cfg_we) limit_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) r_q <= req;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			vic_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hslot_q <= '0;
			fslot_q <= '0;
			nflush_q <= '0;
		end else if (ctl.load) begin
			scan_q <= '0;
			vic_q <= last_q;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			nflush_q <= '0;
		end else if (ctl.scan_step) begin
			scan_q <= scan_q + 1'b1;
			vic_q <= vp;
			if (!hit_q && valid_q[sp] && tag_q[sp] == r_q.block_number) begin
				hit_q <= 1'b1;
				hslot_q <= sp;
			end
			if (!free_q && cnt_q[vp] == '0) begin
				free_q <= 1'b1;
				fslot_q <= vp;
			end
			if (ctl.flush_hit) nflush_q <= nflush_q + 1'b1;
		end
	end

	// entry table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				dirty_q[i] <= 1'b0;
				tag_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			last_q <= '0;
		end else begin
			if (ctl.commit && lookup_cmd && range_ok) begin
				if (hit_q) begin
					if (cnt_q[hslot_q] != CMAX) cnt_q[hslot_q] <= cnt_q[hslot_q] + 1'b1;
					if (r_q.command == CMD_NEW) dirty_q[hslot_q] <= 1'b1;
				end else if (free_q) begin
					tag_q[fslot_q] <= r_q.block_number;
					cnt_q[fslot_q] <= COUNT_BITS'(1);
					valid_q[fslot_q] <= 1'b1;
					dirty_q[fslot_q] <= (r_q.command == CMD_NEW);
					last_q <= fslot_q;
				end
			end
			if (ctl.rel && slot_ok && r_q.command == CMD_RELEASE) begin
				if (cnt_q[sl_idx] != '0)
					cnt_q[sl_idx] <= cnt_q[sl_idx] - 1'b1;
			end
			if (ctl.mark && slot_ok && r_q.command == CMD_MARK) begin
				if (valid_q[sl_idx]) dirty_q[sl_idx] <= 1'b1;
			end
			if (ctl.flush_hit) dirty_q[sp] <= 1'b0;
		end
	end

	// result register; flush results wait in pend_q until the next one or the end, to mark the last
	rsp_t pend_q;
	rsp_t rsp_d;
	logic pend_v_q;
	logic fin;
	assign fin = sts.is_flush && pend_v_q && !ctl.flush_hit && !ctl.scan_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			rsp_valid <= ctl.emit_res || ctl.emit_none || (ctl.flush_hit && pend_v_q) || fin;
			if (ctl.load) pend_v_q <= 1'b0;
			else if (ctl.flush_hit) pend_v_q <= 1'b1;
			else if (fin) pend_v_q <= 1'b0;
		end
	end

	always_comb begin
		rsp_d = rsp;
		if (ctl.emit_none) begin
			rsp_d = '{status: ST_DONE, last: 1'b1, default: '0};
		end else if (ctl.emit_res) begin
			rsp_d = '{last: 1'b1, default: '0};
			if (sts.is_rel_mark) begin
				rsp_d.result_slot = r_q.slot;
				if (!slot_ok) rsp_d.status = ST_RANGE;
				else if (r_q.command == CMD_RELEASE && cnt_q[sl_idx] == '0)
					rsp_d.status = ST_UNDER;
				else rsp_d.status = ST_DONE;
			end else if (!range_ok) begin
				rsp_d.status = ST_RANGE;
			end else if (hit_q) begin
				rsp_d.status = ST_HIT;
				rsp_d.result_slot = 5'(hslot_q);
				rsp_d.clear_request = (r_q.command == CMD_NEW);
			end else if (free_q) begin
				rsp_d.status = ST_ALLOC;
				rsp_d.result_slot = 5'(fslot_q);
				rsp_d.read_request = (r_q.command == CMD_GET);
				rsp_d.clear_request = (r_q.command == CMD_NEW);
				rsp_d.writeback_request = dirty_q[fslot_q];
				rsp_d.writeback_block = dirty_q[fslot_q] ? tag_q[fslot_q] : 32'd0;
			end else begin
				rsp_d.status = ST_NOFREE;
			end
		end else if (ctl.flush_hit) begin
			rsp_d = pend_q;
		end else if (fin) begin
			rsp_d = pend_q;
			rsp_d.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rsp <= rsp_d;
	end

	always_ff @(posedge clk) begin
		if (ctl.flush_hit)
			pend_q <= '{status: ST_FLUSH, result_slot: 5'(sp), writeback_request: 1'b1,
				writeback_block: tag_q[sp], default: '0};
	end
endmodule

### hdl/bbcc_checker.sv
// Port-level checker of the buffer cache controller, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbcc_props (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input bbcc_pkg::rsp_t rsp
);
	import bbcc_pkg::*;

	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	`ASSERT_IMP(a_flush_wb, clk, arst_n, done && rsp.status == ST_FLUSH, rsp.writeback_request)
	`ASSERT_NEXT(a_last_end, clk, arst_n, done && rsp.last, !done)
endmodule

bind block_buffer_cache_control_core bbcc_props u_props (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

### tb/bbcc_checker.sv
// Checker: predicts buffer cache control results and compares them with the block
`timescale 1ns / 1ps
module bbcc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input bbcc_pkg::req_t req,
	input logic done,
	input bbcc_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	output int mismatch_count,
	output int pending_count,
	output int result_count
);
	import bbcc_pkg::*;

	localparam int NENT = ENTRIES_DEF;
	localparam logic [7:0] CNT_MAX = 8'hFF;

	logic [31:0] limit_reg;
	logic valid_q [NENT];
	logic [31:0] tag_q [NENT];
	logic [7:0] cnt_q [NENT];
	logic dirty_q [NENT];
	logic [4:0] alloc_ptr;
	rsp_t expected_rsp [$];

	function automatic rsp_t blank_rsp(status_t st, logic [4:0] sl);
		rsp_t r;
		r = '0;
		r.status = st;
		r.result_slot = sl;
		r.last = 1'b1;
		return r;
	endfunction

	task automatic lookup_block(logic [31:0] blk, logic is_new);
		rsp_t r;
		int j;
		if (blk >= limit_reg) begin
			expected_rsp.push_back(blank_rsp(ST_RANGE, 5'd0));
			return;
		end
		for (int i = 0; i < NENT; i++) begin
			if (valid_q[i] && tag_q[i] == blk) begin
				if (cnt_q[i] < CNT_MAX)
					cnt_q[i]++;
				if (is_new)
					dirty_q[i] = 1'b1;
				r = blank_rsp(ST_HIT, i[4:0]);
				r.clear_request = is_new;
				expected_rsp.push_back(r);
				return;
			end
		end
		j = alloc_ptr;
		for (int i = 0; i < NENT; i++) begin
			j = (j + 1) % NENT;
			if (cnt_q[j] == 0) begin
				r = blank_rsp(ST_ALLOC, j[4:0]);
				r.read_request = !is_new;
				r.clear_request = is_new;
				r.writeback_request = dirty_q[j];
				r.writeback_block = dirty_q[j] ? tag_q[j] : 32'd0;
				tag_q[j] = blk;
				cnt_q[j] = 8'd1;
				valid_q[j] = 1'b1;
				dirty_q[j] = is_new;
				alloc_ptr = j[4:0];
				expected_rsp.push_back(r);
				return;
			end
		end
		expected_rsp.push_back(blank_rsp(ST_NOFREE, 5'd0));
	endtask

	task automatic predict_item(req_t it);
		rsp_t r;
		int n;
		case (it.command)
			CMD_GET: lookup_block(it.block_number, 1'b0);
			CMD_NEW: lookup_block(it.block_number, 1'b1);
			CMD_RELEASE: begin
				if (cnt_q[it.slot] == 0) begin
					expected_rsp.push_back(blank_rsp(ST_UNDER, it.slot));
				end else begin
					cnt_q[it.slot]--;
					expected_rsp.push_back(blank_rsp(ST_DONE, it.slot));
				end
			end
			CMD_MARK: begin
				if (valid_q[it.slot])
					dirty_q[it.slot] = 1'b1;
				expected_rsp.push_back(blank_rsp(ST_DONE, it.slot));
			end
			CMD_FLUSH: begin
				n = 0;
				for (int i = 0; i < NENT && n < FLUSH_MAX; i++) begin
					if (dirty_q[i]) begin
						dirty_q[i] = 1'b0;
						r = blank_rsp(ST_FLUSH, i[4:0]);
						r.last = 1'b0;
						r.writeback_request = 1'b1;
						r.writeback_block = tag_q[i];
						expected_rsp.push_back(r);
						n++;
					end
				end
				if (n == 0)
					expected_rsp.push_back(blank_rsp(ST_DONE, 5'd0));
				else
					expected_rsp[$].last = 1'b1;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			limit_reg = '0;
			alloc_ptr = '0;
			for (int i = 0; i < NENT; i++) begin
				valid_q[i] = 1'b0;
				tag_q[i] = '0;
				cnt_q[i] = '0;
				dirty_q[i] = 1'b0;
			end
			expected_rsp.delete();
			mismatch_count = 0;
			result_count = 0;
		end else begin
			if (done) begin
				result_count++;
				if (expected_rsp.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result %p", $time, rsp);
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.status !== e.status || rsp.result_slot !== e.result_slot
						|| rsp.read_request !== e.read_request
						|| rsp.clear_request !== e.clear_request
						|| rsp.writeback_request !== e.writeback_request
						|| rsp.writeback_block !== e.writeback_block
						|| rsp.last !== e.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch exp %p got %p", $time, e, rsp);
					end
				end
			end
			if (cfg_we)
				limit_reg = cfg_wdata;
			if (start && !busy)
				predict_item(req);
		end
		pending_count = expected_rsp.size();
	end
endmodule

### tb/testbench.sv
// Top of the buffer cache controller testbench: stimulus, idling and verdict
`timescale 1ns / 1ps
module testbench;
	import bbcc_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	int mismatch_count;
	int pending_count;
	int result_count;
	int cycle_count = 0;
	int idle_pct = 0;
	int item_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	block_buffer_cache_control_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	bbcc_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.mismatch_count(mismatch_count), .pending_count(pending_count),
		.result_count(result_count)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL block_buffer_cache_control_core");
			$finish;
		end
	end

	task automatic send_item(logic [2:0] cmd, logic [31:0] blk, logic [4:0] sl);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		req.command = cmd;
		req.block_number = blk;
		req.slot = sl;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		item_count++;
	endtask

	// wait for all results, then for a possible silent item to finish
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (ENTRIES_DEF + 10) @(negedge clk);
	endtask

	task automatic write_limit(logic [31:0] v);
		settle();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_items(int n);
		int r;
		logic [2:0] cmd;
		logic [31:0] blk;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 35) cmd = CMD_GET;
			else if (r < 50) cmd = CMD_NEW;
			else if (r < 75) cmd = CMD_RELEASE;
			else if (r < 85) cmd = CMD_MARK;
			else if (r < 93) cmd = CMD_FLUSH;
			else cmd = 3'($urandom_range(7, 5));
			blk = ($urandom_range(99) < 80) ? 32'($urandom_range(47)) : $urandom;
			send_item(cmd, blk, 5'($urandom_range(31)));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// limit zero rejects everything
		send_item(CMD_GET, 32'd5, 5'd0);
		send_item(CMD_NEW, 32'd0, 5'd0);
		write_limit(32'hFFFF_FFFF);
		send_item(CMD_GET, 32'hFFFF_FFFF, 5'd0);
		send_item(CMD_GET, 32'hFFFF_FFFE, 5'd0);
		send_item(CMD_GET, 32'd0, 5'd0);
		send_item(CMD_GET, 32'd0, 5'd0);
		send_item(CMD_NEW, 32'd0, 5'd0);
		send_item(CMD_NEW, 32'd7, 5'd0);
		send_item(CMD_MARK, 32'd0, 5'd1);
		send_item(CMD_MARK, 32'd0, 5'd31);
		send_item(CMD_RELEASE, 32'd0, 5'd1);
		send_item(CMD_RELEASE, 32'd0, 5'd1);
		send_item(CMD_RELEASE, 32'd0, 5'd31);
		send_item(CMD_FLUSH, 32'd0, 5'd0);
		send_item(CMD_FLUSH, 32'd0, 5'd0);
		send_item(3'd5, 32'd0, 5'd0);
		send_item(3'd6, 32'hFFFF_FFFF, 5'd31);
		send_item(3'd7, 32'd0, 5'd0);
		// use count saturation on one block
		for (int k = 0; k < 257; k++)
			send_item(CMD_GET, 32'h1234_5678, 5'd0);
		// fill the table until no entry is free, then free a few and recycle
		for (int k = 0; k < 33; k++)
			send_item(CMD_NEW, 32'd1000 + k, 5'd0);
		for (int k = 0; k < 8; k++)
			send_item(CMD_RELEASE, 32'd0, 5'(k));
		for (int k = 0; k < 4; k++)
			send_item(CMD_GET, 32'd2000 + k, 5'd0);
		settle();

		idle_pct = 37;
		random_items(6);
		write_limit(32'd40);
		idle_pct = 80;
		random_items(6);
		write_limit(32'd0);
		random_items(2);
		write_limit(32'hFFFF_FFFF);
		idle_pct = 0;
		random_items(6);

		settle();
		$display("%0d items sent, %0d results checked, limits 0, 40 and all ones",
			item_count, result_count);
		$display("covered range rejects, hits, victim writebacks, saturation, full table");
		if (mismatch_count == 0 && pending_count == 0)
			$display("PASS block_buffer_cache_control_core");
		else
			$display("FAIL block_buffer_cache_control_core");
		$finish;
	end
endmodule
